### rtl/tps_pkg.sv
// Shared types and constants for the tick process scheduler.
// Used by the controller, the datapath and the top level; no dependencies.
package tps_pkg;

  localparam int IDX_W       = 4;
  localparam int MAX_ENTRIES = 1 << IDX_W;
  localparam int CNT_W       = IDX_W + 1;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [1:0] KEY_BURST    = 2'd0;
  localparam logic [1:0] KEY_ARRIVAL  = 2'd1;
  localparam logic [1:0] KEY_PRIORITY = 2'd2;

  localparam logic [1:0] CFG_KEY_SELECT  = 2'd0;
  localparam logic [1:0] CFG_PREEMPTIVE  = 2'd1;
  localparam logic [1:0] CFG_ENTRY_COUNT = 2'd2;

  localparam int CFG_W = 5;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] entry_index;
    logic [15:0]      burst_time;
    logic [15:0]      arrival_time;
    logic [7:0]       priority_value;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] selected_index;
    logic             selected_valid;
    logic             entry_finished;
    logic [15:0]      waiting_ticks;
    logic             entry_done;
    logic [31:0]      time_now;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_APPLY,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic scan;
    logic apply;
    logic emit;
  } tps_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       n_zero;
    logic       scan_last;
    logic       out_free;
  } tps_status_t;

endpackage

### rtl/tps_ctrl.sv
// Sequencing state machine of the tick process scheduler.
// Depends on tps_pkg for the state type and the command and status structs.
module tps_ctrl
  import tps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  tps_status_t status,
  output tps_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (status.mode)
            MODE_LOAD: state_next = ST_LOAD;
            MODE_TICK: state_next = status.n_zero ? ST_APPLY : ST_SCAN;
            default:   state_next = ST_EMIT;
          endcase
        end
      end
      ST_LOAD:  state_next = ST_EMIT;
      ST_SCAN: begin
        if (status.scan_last) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: state_next = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall  = (state != ST_IDLE);
    cmd.accept = (state == ST_IDLE) && req_valid;
    cmd.load   = (state == ST_LOAD);
    cmd.scan   = (state == ST_SCAN);
    cmd.apply  = (state == ST_APPLY);
    cmd.emit   = (state == ST_EMIT) && status.out_free;
  end

endmodule

### rtl/tps_dp.sv
// Datapath of the tick process scheduler: entry table, scan registers,
// configuration registers and the response register. Depends on tps_pkg.
module tps_dp
  import tps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  req_t             req,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  tps_cmd_t         cmd,
  output tps_status_t      status,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp
);

  logic [1:0]             key_sel;
  logic                   preempt;
  logic [CNT_W-1:0]       entry_count;

  req_t                   req_q;
  logic [15:0]            burst   [MAX_ENTRIES];
  logic [15:0]            arrival [MAX_ENTRIES];
  logic [7:0]             prio    [MAX_ENTRIES];
  logic [15:0]            waiting [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] arrived;
  logic [MAX_ENTRIES-1:0] done;

  logic [31:0]            tick_time;
  logic [IDX_W-1:0]       run_idx;
  logic                   run_valid;

  logic [CNT_W-1:0]       cnt;
  logic [15:0]            best_key;
  logic [IDX_W-1:0]       best_idx;
  logic                   best_valid;
  logic                   hold_ok;

  logic [IDX_W-1:0]       res_sel;
  logic                   res_valid;
  logic                   res_fin;

  logic [CNT_W-1:0]       n_used;
  logic                   hold_use;
  logic                   sel_valid;
  logic [IDX_W-1:0]       sel_idx;
  logic [IDX_W-1:0]       addr;
  logic                   arr_hit;
  logic                   arrived_new;
  logic                   elig;
  logic [15:0]            key;
  logic                   better;
  logic [15:0]            burst_dec;
  logic                   dec_zero;
  logic                   is_read;

  always_comb begin
    n_used    = (entry_count > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : entry_count;
    hold_use  = !preempt && run_valid && hold_ok;
    sel_valid = hold_use || best_valid;
    sel_idx   = hold_use ? run_idx : best_idx;
    if (cmd.scan) begin
      addr = cnt[IDX_W-1:0];
    end else if (cmd.apply) begin
      addr = sel_idx;
    end else begin
      addr = req_q.entry_index;
    end
    arr_hit     = (tick_time[31:16] == 16'd0) && (arrival[addr] == tick_time[15:0]);
    arrived_new = arrived[addr] || arr_hit;
    elig        = arrived_new && !done[addr];
    case (key_sel)
      KEY_BURST:   key = burst[addr];
      KEY_ARRIVAL: key = arrival[addr];
      default:     key = {8'd0, prio[addr]};
    endcase
    better    = elig && (!best_valid || (key < best_key));
    burst_dec = burst[addr] - 16'd1;
    dec_zero  = (burst_dec == 16'd0);
    is_read   = (req_q.mode == MODE_READ);
  end

  always_comb begin
    status.mode      = req.mode;
    status.n_zero    = (n_used == '0);
    status.scan_last = (cnt == n_used - CNT_W'(1));
    status.out_free  = !rsp_valid || !rsp_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_sel     <= KEY_ARRIVAL;
      preempt     <= 1'b1;
      entry_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_SELECT:  key_sel     <= cfg_data[1:0];
        CFG_PREEMPTIVE:  preempt     <= cfg_data[0];
        CFG_ENTRY_COUNT: entry_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q <= req;
    end
    if (cmd.load) begin
      burst[addr]   <= req_q.burst_time;
      arrival[addr] <= req_q.arrival_time;
      prio[addr]    <= req_q.priority_value;
      waiting[addr] <= 16'd0;
    end
    if (cmd.apply && sel_valid) begin
      burst[addr] <= burst_dec;
      for (int j = 0; j < MAX_ENTRIES; j++) begin
        if ((IDX_W'(j) != sel_idx) && (CNT_W'(j) < n_used) && arrived[j] && !done[j] &&
            (waiting[j] != 16'hFFFF)) begin
          waiting[j] <= waiting[j] + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arrived   <= '0;
      done      <= '0;
      tick_time <= '0;
      run_idx   <= '0;
      run_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        arrived[addr] <= 1'b0;
        done[addr]    <= (req_q.burst_time == 16'd0);
        tick_time     <= '0;
        run_idx       <= '0;
        run_valid     <= 1'b0;
      end
      if (cmd.scan) begin
        arrived[addr] <= arrived_new;
      end
      if (cmd.apply && sel_valid) begin
        if (dec_zero) begin
          done[addr] <= 1'b1;
        end
        tick_time <= tick_time + 32'd1;
        run_valid <= !dec_zero;
        run_idx   <= dec_zero ? '0 : sel_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      best_key   <= '0;
      best_idx   <= '0;
      best_valid <= 1'b0;
      hold_ok    <= 1'b0;
      res_sel    <= '0;
      res_valid  <= 1'b0;
      res_fin    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        cnt        <= '0;
        best_valid <= 1'b0;
        hold_ok    <= 1'b0;
        res_sel    <= '0;
        res_valid  <= 1'b0;
        res_fin    <= 1'b0;
      end
      if (cmd.scan) begin
        cnt <= cnt + CNT_W'(1);
        if (better) begin
          best_key   <= key;
          best_idx   <= addr;
          best_valid <= 1'b1;
        end
        if (run_valid && (addr == run_idx)) begin
          hold_ok <= elig;
        end
      end
      if (cmd.apply) begin
        res_valid <= sel_valid;
        res_sel   <= sel_valid ? sel_idx : '0;
        res_fin   <= sel_valid && dec_zero;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.selected_index <= res_sel;
      rsp.selected_valid <= res_valid;
      rsp.entry_finished <= res_fin;
      rsp.waiting_ticks  <= is_read ? waiting[addr] : 16'd0;
      rsp.entry_done     <= is_read && done[addr];
      rsp.time_now       <= tick_time;
    end
  end

`ifndef SYNTH
  a_time_advance: assert property (@(posedge clk) disable iff (rst)
    cmd.apply && sel_valid |=> tick_time == $past(tick_time) + 32'd1)
    else $error("tick time did not advance after an entry ran");

  a_time_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.apply && !sel_valid |=> tick_time == $past(tick_time))
    else $error("tick time moved on an idle tick");

  a_running_arrived: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> arrived[run_idx])
    else $error("running entry is not marked arrived");

  a_finish_done: assert property (@(posedge clk) disable iff (rst)
    cmd.apply && sel_valid && dec_zero |=> done[$past(sel_idx)])
    else $error("finished entry was not marked done");
`endif

endmodule

### rtl/tick_process_scheduler_core.sv
// Tick-driven process scheduler with a table of sixteen entries, top level.
// Request channel: req_valid, req_stall and a req_t payload. A request loads an
// entry, advances one tick, or reads an entry's waiting count and done flag.
// Response channel: rsp_valid, rsp_stall and an rsp_t payload; each request
// gives exactly one response, in request order.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 key select,
// 1 preemptive, 2 entry count) in the same cycle; write only while idle.
// A load passes through the load state and a read goes straight to the emit
// state. A tick scans the first n entries, where n is the entry count clamped
// to sixteen: one entry of the table is scanned per cycle for arrival and the
// minimum key, then the apply state applies the choice before the emit state.
// One request is in flight at a time; the next request is accepted as soon
// as the previous response sits in the output register, even while the
// receiver stalls it. A stalled response holds until taken, and the block
// then holds req_stall high once its next result is ready.
// Reset clears the arrived and done flags, tick time, the running entry and
// sets key select 1, preemptive 1, entry count 0. Entry fields are undefined
// until loaded.
module tick_process_scheduler_core
  import tps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  tps_cmd_t    cmd;
  tps_status_t status;

  tps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tps_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

### tb/tb_top.sv
// Self-checking testbench for tick_process_scheduler_core: drives load, tick, read and
// spare requests under random idling and back-pressure; checks each response in order.
// Depends on tps_pkg for the payload types, mode, key and register codes.
module tb_top;
  import tps_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int LONG_TICKS = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_KEY_SELECT;
  logic [CFG_W-1:0] cfg_data = '0;

  tick_process_scheduler_core dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scheduler state as the testbench predicts it.
  bit [15:0] burst_left_tbl [MAX_ENTRIES];
  bit [15:0] arrival_tbl [MAX_ENTRIES];
  bit [7:0] prio_tbl [MAX_ENTRIES];
  bit [15:0] wait_tbl [MAX_ENTRIES];
  bit done_tbl [MAX_ENTRIES];
  bit arrived_tbl [MAX_ENTRIES];
  bit [31:0] tick_now = '0;
  bit holder_valid = 1'b0;
  bit [IDX_W-1:0] holder_idx = '0;
  bit [1:0] cfg_key = KEY_ARRIVAL;
  bit cfg_preempt = 1'b1;
  bit [CFG_W-1:0] cfg_count = '0;

  rsp_t outcome_q [$];
  rsp_t want_rsp;
  int mismatches = 0;
  int cycle_count = 0;
  int n_loads = 0, n_ticks = 0, n_reads = 0, n_spare = 0;
  int n_checked = 0, n_ran = 0;

  int gap_pct = 30;
  int stall_pct = 30;
  int send_burst = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  function automatic bit [15:0] key_of(int i);
    case (cfg_key)
      KEY_BURST:   return burst_left_tbl[i];
      KEY_ARRIVAL: return arrival_tbl[i];
      default:     return {8'd0, prio_tbl[i]};
    endcase
  endfunction

  function automatic rsp_t scheduler_outcome(req_t r);
    rsp_t o;
    int n;
    bit found;
    bit fin;
    bit [15:0] best;
    bit [IDX_W-1:0] pick;
    o = '0;
    found = 1'b0;
    fin = 1'b0;
    best = '0;
    pick = '0;
    n = (cfg_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(cfg_count);
    case (r.mode)
      MODE_LOAD: begin
        burst_left_tbl[r.entry_index] = r.burst_time;
        arrival_tbl[r.entry_index] = r.arrival_time;
        prio_tbl[r.entry_index] = r.priority_value;
        wait_tbl[r.entry_index] = '0;
        arrived_tbl[r.entry_index] = 1'b0;
        done_tbl[r.entry_index] = (r.burst_time == 16'd0);
        tick_now = '0;
        holder_valid = 1'b0;
        holder_idx = '0;
      end
      MODE_TICK: begin
        for (int i = 0; i < n; i++) begin
          if (!arrived_tbl[i] && {16'd0, arrival_tbl[i]} == tick_now) arrived_tbl[i] = 1'b1;
        end
        if (!cfg_preempt && holder_valid && holder_idx < n && arrived_tbl[holder_idx] &&
            !done_tbl[holder_idx]) begin
          pick = holder_idx;
          found = 1'b1;
        end else begin
          for (int i = 0; i < n; i++) begin
            if (arrived_tbl[i] && !done_tbl[i] && (!found || key_of(i) < best)) begin
              best = key_of(i);
              pick = IDX_W'(i);
              found = 1'b1;
            end
          end
        end
        if (found) begin
          for (int i = 0; i < n; i++) begin
            if (i == pick) begin
              burst_left_tbl[i] = burst_left_tbl[i] - 16'd1;
              if (burst_left_tbl[i] == 16'd0) begin
                done_tbl[i] = 1'b1;
                fin = 1'b1;
              end
            end else if (arrived_tbl[i] && !done_tbl[i] && wait_tbl[i] != 16'hFFFF) begin
              wait_tbl[i] = wait_tbl[i] + 16'd1;
            end
          end
          tick_now = tick_now + 32'd1;
          holder_valid = !fin;
          holder_idx = fin ? '0 : pick;
        end
        o.selected_index = pick;
        o.selected_valid = found;
        o.entry_finished = fin;
      end
      MODE_READ: begin
        o.waiting_ticks = wait_tbl[r.entry_index];
        o.entry_done = done_tbl[r.entry_index];
      end
      default: ;
    endcase
    o.time_now = tick_now;
    return o;
  endfunction

  function automatic req_t make_req(logic [1:0] mode, int idx, int burst, int arr, int prio);
    req_t r;
    r.mode = mode;
    r.entry_index = idx[IDX_W-1:0];
    r.burst_time = burst[15:0];
    r.arrival_time = arr[15:0];
    r.priority_value = prio[7:0];
    return r;
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  task automatic issue(req_t r);
    int gap;
    if (send_burst == 0) begin
      send_burst = $urandom_range(1, 20);
      gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    send_burst--;
    @(negedge clk);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    outcome_q.push_back(scheduler_outcome(r));
    case (r.mode)
      MODE_LOAD: n_loads++;
      MODE_TICK: n_ticks++;
      MODE_READ: n_reads++;
      default:   n_spare++;
    endcase
  endtask

  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] index, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_KEY_SELECT:  cfg_key = value[1:0];
      CFG_PREEMPTIVE:  cfg_preempt = value[0];
      CFG_ENTRY_COUNT: cfg_count = value;
      default: ;
    endcase
  endtask

  // The receiver stalls in random stretches, or holds off for a long stretch on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      stall_left = $urandom_range(0, 12);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      n_checked++;
      if (outcome_q.size() == 0) begin
        mismatches++;
        $display("%0t: response with no request outstanding, got %0h", $time, rsp);
      end else begin
        want_rsp = outcome_q.pop_front();
        if (want_rsp.selected_valid) n_ran++;
        check_field("selected_index", want_rsp.selected_index, rsp.selected_index);
        check_field("selected_valid", want_rsp.selected_valid, rsp.selected_valid);
        check_field("entry_finished", want_rsp.entry_finished, rsp.entry_finished);
        check_field("waiting_ticks", want_rsp.waiting_ticks, rsp.waiting_ticks);
        check_field("entry_done", want_rsp.entry_done, rsp.entry_done);
        check_field("time_now", want_rsp.time_now, rsp.time_now);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses outstanding.",
               cycle_count, outcome_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    issue(make_req(MODE_SPARE, 15, 16'hFFFF, 16'hFFFF, 8'hFF));
    issue(make_req(MODE_TICK, 0, 0, 0, 0));
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      issue(make_req(MODE_LOAD, i,
                     (i == 0) ? 0 : (i == 1) ? 16'hFFFF : i + 1,
                     (i == 1) ? 16'hFFFF : i % 4,
                     (i == 1) ? 8'hFF : (i == 2) ? 0 : 16 - i));
    end
    settle();
    write_cfg(CFG_ENTRY_COUNT, 5'd16);
    repeat (4) issue(make_req(MODE_TICK, 0, 0, 0, 0));
    issue(make_req(MODE_READ, 0, 0, 0, 0));
    issue(make_req(MODE_READ, 15, 0, 0, 0));
  endtask

  task automatic run_workload(int quota);
    int sent;
    int n;
    int k;
    int t;
    sent = 0;
    n = (cfg_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(cfg_count);
    while (sent < quota) begin
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(2))
          0: issue(make_req(MODE_SPARE, $urandom_range(15), $urandom_range(16'hFFFF),
                            $urandom_range(16'hFFFF), $urandom_range(8'hFF)));
          1: issue(make_req(MODE_LOAD, $urandom_range(15), $urandom_range(16'hFFFF),
                            $urandom_range(16'hFFFF), $urandom_range(8'hFF)));
          default: issue(make_req(MODE_READ, $urandom_range(15), $urandom_range(16'hFFFF),
                                  $urandom_range(16'hFFFF), $urandom_range(8'hFF)));
        endcase
        sent++;
      end else begin
        k = $urandom_range(1, 4);
        for (int j = 0; j < k; j++) begin
          issue(make_req(MODE_LOAD, (n == 0) ? $urandom_range(15) : $urandom_range(n - 1),
                         $urandom_range(1, 6), $urandom_range(0, 4), $urandom_range(8'hFF)));
          sent++;
        end
        t = $urandom_range(1, 24);
        for (int j = 0; j < t; j++) begin
          if ($urandom_range(9) == 0)
            issue(make_req(MODE_READ, $urandom_range(15), 0, 0, 0));
          else
            issue(make_req(MODE_TICK, $urandom_range(15), $urandom_range(16'hFFFF), 0, 0));
          sent++;
        end
      end
    end
  endtask

  task automatic test_config_sweep();
    logic [1:0] keys [14] = '{KEY_BURST, KEY_BURST, KEY_ARRIVAL, KEY_ARRIVAL, KEY_PRIORITY,
                             KEY_PRIORITY, 2'd3, 2'd3, KEY_BURST, KEY_PRIORITY,
                             KEY_ARRIVAL, KEY_BURST, KEY_PRIORITY, KEY_ARRIVAL};
    bit pre [14] = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 1, 1, 0, 0, 1};
    int counts [14] = '{4, 4, 8, 3, 16, 16, 5, 2, 1, 0, 17, 31, 7, 16};
    for (int s = 0; s < 14; s++) begin
      settle();
      write_cfg(CFG_KEY_SELECT, {3'd0, keys[s]});
      write_cfg(CFG_PREEMPTIVE, {4'd0, pre[s]});
      write_cfg(CFG_ENTRY_COUNT, counts[s][CFG_W-1:0]);
      gap_pct = (s % 3 == 2) ? 0 : 30;
      stall_pct = (s % 3 == 2) ? 0 : 30;
      run_workload(120);
    end
  endtask

  task automatic test_backpressure();
    stall_pct = 0;
    gap_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++) begin
      if (i % 4 == 3)
        issue(make_req(MODE_READ, $urandom_range(15), 0, 0, 0));
      else
        issue(make_req(MODE_TICK, 0, 0, 0, 0));
    end
    stall_pct = 30;
    gap_pct = 30;
  endtask

  // One long job keeps two others waiting for many ticks, and an entry whose arrival
  // lies far ahead never becomes eligible.
  task automatic test_long_wait();
    settle();
    write_cfg(CFG_KEY_SELECT, {3'd0, KEY_PRIORITY});
    write_cfg(CFG_PREEMPTIVE, 5'd1);
    write_cfg(CFG_ENTRY_COUNT, 5'd4);
    gap_pct = 0;
    stall_pct = 5;
    issue(make_req(MODE_LOAD, 0, 16'hFFFF, 0, 0));
    issue(make_req(MODE_LOAD, 1, 1, 0, 8'hFF));
    issue(make_req(MODE_LOAD, 2, 20, 0, 1));
    issue(make_req(MODE_LOAD, 3, 1, 16'hFFFF, 2));
    repeat (LONG_TICKS) issue(make_req(MODE_TICK, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++) issue(make_req(MODE_READ, i, 0, 0, 0));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_long_wait();
    settle();
    $display("Sent %0d requests: %0d loads, %0d ticks (%0d ran an entry), %0d reads, %0d spare.",
             n_loads + n_ticks + n_reads + n_spare, n_loads, n_ticks, n_ran, n_reads, n_spare);
    $display("Covered all selection keys, both preemption modes, entry counts 0 to 31, %s",
             "a long receiver hold-off and a long wait behind one job.");
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
